/* rtl/lphm_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the hash map.
package lphm_pkg;

  localparam int unsigned SLOTS_DEF      = 1024;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned TSIZE_W   = 11;
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd11;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned FIELD_W   = 32;

  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // clear one slot of the slot memory
    logic load;      // take a new request
    logic mod_step;  // one bit of the home slot remainder
    logic read;      // read the slot under the probe index
    logic eval;      // look at the slot that was read
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic op_none;
    logic mod_last;
    logic finish;
  } stat_t;

endpackage

/* rtl/linear_probe_hash_map.sv */
// Top level of the linear probing key/value hash map.
//
//   Channel   Direction  Handshake              Payload
//   request   in         start / busy           operation_i, key_i, value_i
//   result    out        done_o strobe          status_o, read_value_o, live_count_o
//   config    in         cfg_valid_i/ready_o    cfg_data_i (table size)
//
// A request first reduces the key modulo the table size (one key bit per cycle in the
// restoring remainder unit), then reads each probed slot from the slot memory and
// examines its registered data in turn. The result strobe is registered and rises in the
// cycle after the last probe is examined. An OP_NONE request skips the walk and answers
// in the cycle after it is taken. After reset the block clears every slot, with busy high.
// The receiver cannot stall results; each result is shown for exactly one cycle.
module linear_probe_hash_map #(
  parameter int unsigned SLOTS      = lphm_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = lphm_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation_i,
  input  logic [lphm_pkg::FIELD_W-1:0]      key_i,
  input  logic [lphm_pkg::FIELD_W-1:0]      value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lphm_pkg::TSIZE_W-1:0]      cfg_data_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [lphm_pkg::FIELD_W-1:0]      read_value_o,
  output logic [lphm_pkg::COUNT_W-1:0]      live_count_o
);

  lphm_pkg::cmd_t  cmd;
  lphm_pkg::stat_t stat;

  // The table size register can always take a write.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the clearing pass, the remainder and the probe walk.
  lphm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // The datapath owns the slot memory, the entry count and the result registers.
  lphm_datapath #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .live_count_o (live_count_o)
  );

endmodule

/* rtl/lphm_ctrl.sv */
// Controller state machine for the hash map: clearing pass, remainder, probe walk.
module lphm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  lphm_pkg::stat_t stat_i,
  output lphm_pkg::cmd_t  cmd_o,
  output logic            busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (!stat_i.op_none) state_d = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.finish ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* rtl/lphm_datapath.sv */
// Datapath of the hash map: slot memory, remainder unit, probe registers and result.
module lphm_datapath #(
  parameter int unsigned SLOTS      = lphm_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS   = lphm_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lphm_pkg::cmd_t                    cmd_i,
  output lphm_pkg::stat_t                   stat_o,
  input  logic [1:0]                        operation_i,
  input  logic [lphm_pkg::FIELD_W-1:0]      key_i,
  input  logic [lphm_pkg::FIELD_W-1:0]      value_i,
  input  logic                              cfg_valid_i,
  input  logic [lphm_pkg::TSIZE_W-1:0]      cfg_data_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [lphm_pkg::FIELD_W-1:0]      read_value_o,
  output logic [lphm_pkg::COUNT_W-1:0]      live_count_o
);

  localparam int unsigned KW  = (KEY_BITS < lphm_pkg::FIELD_W) ? KEY_BITS : lphm_pkg::FIELD_W;
  localparam int unsigned VW  = (VALUE_BITS < lphm_pkg::FIELD_W) ?
                                VALUE_BITS : lphm_pkg::FIELD_W;
  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned SW  = $clog2(SLOTS + 1);
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned KCW = (KW > 1) ? $clog2(KW) : 1;
  localparam int unsigned MW  = 2 + KW + VW;

  logic [MW-1:0] mem [SLOTS];

  logic [lphm_pkg::TSIZE_W-1:0] tsize_q;
  logic [1:0]     op_q;
  logic [KW-1:0]  key_q, div_q;
  logic [VW-1:0]  val_q;
  logic [SW-1:0]  rem_q;
  logic [KCW-1:0] bit_q;
  logic [IW-1:0]  idx_q, tomb_q;
  logic           have_tomb_q;
  logic [SW-1:0]  n_q;
  logic [MW-1:0]  rdata_q;
  logic [CW-1:0]  count_q, count_d;
  logic           done_q, done_d;
  logic [1:0]     status_q, status_d;
  logic [VW-1:0]  rv_q, rv_d;

  // Effective table size, saturated to 2 .. SLOTS.
  logic [31:0] ts32, size32;
  logic [SW-1:0] size;
  always_comb begin
    ts32 = 32'(tsize_q);
    if (ts32 < 32'd2) size32 = 32'd2;
    else if (ts32 > 32'(SLOTS)) size32 = 32'(SLOTS);
    else size32 = ts32;
  end
  assign size = size32[SW-1:0];

  // One restoring step of key modulo size.
  logic [SW:0]   rem_sh;
  logic [SW-1:0] rem_nxt;
  always_comb begin
    rem_sh = {rem_q, div_q[KW-1]};
    if (rem_sh >= {1'b0, size}) rem_sh = rem_sh - {1'b0, size};
    rem_nxt = rem_sh[SW-1:0];
  end

  // Look at the slot just read.
  logic          occ, del, empty, is_hit, last, have_now, finish;
  logic [KW-1:0] rkey;
  logic [VW-1:0] rval;
  logic [IW-1:0] tomb_now, spot, idx_inc;
  logic          have_spot;
  logic [SW-1:0] idx_p1, n_p1;

  always_comb begin
    occ      = rdata_q[MW-1];
    del      = rdata_q[MW-2];
    rkey     = rdata_q[KW+VW-1:VW];
    rval     = rdata_q[VW-1:0];
    empty    = !occ;
    is_hit   = occ && !del && (rkey == key_q);
    n_p1     = n_q + SW'(1);
    last     = (n_p1 == size);
    finish   = empty || is_hit || last;
    have_now = have_tomb_q || (occ && del);
    tomb_now = have_tomb_q ? tomb_q : idx_q;
    if (empty) begin
      spot      = tomb_now;
      have_spot = 1'b1;
    end else begin
      spot      = tomb_now;
      have_spot = have_now;
    end
    idx_p1  = SW'(idx_q) + SW'(1);
    idx_inc = (idx_p1 >= size) ? '0 : idx_p1[IW-1:0];
  end

  // Memory write selection and result.
  logic          we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata;

  always_comb begin
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = '0;
    done_d   = 1'b0;
    status_d = lphm_pkg::ST_OK;
    rv_d     = '0;
    count_d  = count_q;
    if (cmd_i.clear) begin
      we = 1'b1;
    end else if (cmd_i.load && (operation_i == lphm_pkg::OP_NONE)) begin
      done_d = 1'b1;
    end else if (cmd_i.eval && finish) begin
      done_d = 1'b1;
      if (is_hit) begin
        unique case (op_q)
          lphm_pkg::OP_GET: rv_d = rval;
          lphm_pkg::OP_PUT: begin
            we    = 1'b1;
            wdata = {2'b10, key_q, val_q};
          end
          lphm_pkg::OP_REMOVE: begin
            we    = 1'b1;
            wdata = {2'b11, rkey, rval};
            if (count_q != '0) count_d = count_q - CW'(1);
          end
          default: ;
        endcase
      end else begin
        if (op_q == lphm_pkg::OP_PUT) begin
          if (have_spot) begin
            we      = 1'b1;
            waddr   = spot;
            wdata   = {2'b10, key_q, val_q};
            count_d = count_q + CW'(1);
          end else begin
            status_d = lphm_pkg::ST_FULL;
          end
        end else begin
          status_d = lphm_pkg::ST_NOTFOUND;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.read) rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= lphm_pkg::TSIZE_RESET;
      idx_q   <= '0;
      bit_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) tsize_q <= cfg_data_i;
      count_q <= count_d;
      done_q  <= done_d;
      if (cmd_i.clear) begin
        idx_q <= stat_o.clear_last ? '0 : idx_q + IW'(1);
      end else if (cmd_i.load) begin
        bit_q <= '0;
      end else if (cmd_i.mod_step) begin
        bit_q <= bit_q + KCW'(1);
        if (stat_o.mod_last) idx_q <= rem_nxt[IW-1:0];
      end else if (cmd_i.eval && !finish) begin
        idx_q <= idx_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rv_q     <= rv_d;
    if (cmd_i.load) begin
      op_q  <= operation_i;
      key_q <= key_i[KW-1:0];
      div_q <= key_i[KW-1:0];
      val_q <= value_i[VW-1:0];
      rem_q <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_nxt;
      div_q <= div_q << 1;
      if (stat_o.mod_last) begin
        n_q         <= '0;
        have_tomb_q <= 1'b0;
      end
    end else if (cmd_i.eval && !finish) begin
      n_q <= n_p1;
      if (del && !have_tomb_q) begin
        tomb_q      <= idx_q;
        have_tomb_q <= 1'b1;
      end
    end
  end

  assign stat_o.clear_last = (32'(idx_q) == 32'(SLOTS - 1));
  assign stat_o.op_none    = (operation_i == lphm_pkg::OP_NONE);
  assign stat_o.mod_last   = (bit_q == KCW'(KW - 1));
  assign stat_o.finish     = finish;

  logic [31:0] cnt32;
  assign cnt32        = 32'(count_q);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = lphm_pkg::FIELD_W'(rv_q);
  assign live_count_o = cnt32[lphm_pkg::COUNT_W-1:0];

endmodule
